// ----- hw/rtl/plce_pkg.sv -----
// plasma led color engine: shared constants, types and the quarter-wave sine table
`default_nettype none
package plce_pkg;

    localparam int KEY_COUNT        = 256;
    localparam int OSCILLATORS      = 18;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int KEY_AW     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int SINE_AW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int OSC_AW     = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW        = 1;
    localparam int CFG_IW     = 1;
    localparam int CFG_DW     = 22;

    localparam int ONE_Q16          = 65536;
    localparam int SEVEN_TENTHS_Q16 = 45875;
    localparam int SLEW_Q16         = 262;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_DW-1:0] SHARPNESS_RESET = 22'd65536;
    localparam logic [CFG_DW-1:0] SPEED_RESET     = 22'd655360;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_RENDER = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_SHARPNESS = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_SPEED     = 1'd1;

    typedef enum logic [1:0] {
        K_TICK,
        K_RENDER,
        K_LOAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         key;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [OSC_AW-1:0]  osc;
        logic [15:0]        phase;
        logic [15:0]        rate;
    } t_op;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TK_RATE,
        B_TK_PHASE,
        B_TK_SINE,
        B_TK_COEF,
        B_SQ_XX,
        B_SQ_YY,
        B_SQ_XY,
        B_SQ_DONE,
        B_TM_MUL,
        B_TM_ACC,
        B_SC_MUL,
        B_SC_ACC,
        B_WRITE
    } t_bstate;

    typedef logic [16:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // taylor series of sin on a first-quadrant angle, evaluated at elaboration
    function automatic t_sine_tab sine_build();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k <= 6; k++) begin
                term = (((term * x) >> 30) * x) >> 30;
                case (k)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    default: term = term / 156;
                endcase
                if (k[0]) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            s = (s + 64'd8192) >> 14;
            tab[i] = (s > 64'd65536) ? 17'd65536 : 17'(s);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = sine_build();

endpackage
`default_nettype wire

// ----- hw/rtl/plce_in_if.sv -----
// input channel of the plasma led color engine
`default_nettype none
interface plce_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         key_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [4:0]         osc_index;
    logic [15:0]        osc_phase;
    logic [15:0]        osc_rate;

    modport source (
        output valid, mode, key_index, pos_x, pos_y, osc_index, osc_phase, osc_rate,
        input  ready
    );
    modport sink (
        input  valid, mode, key_index, pos_x, pos_y, osc_index, osc_phase, osc_rate,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/plce_out_if.sv -----
// result channel of the plasma led color engine
`default_nettype none
interface plce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid, key_out, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, key_out, red, green, blue,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/plasma_led_color_engine_core.sv -----
// plasma led color engine top level
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    mode, key_index, pos_x, pos_y, osc_index, osc_phase, osc_rate
//  o_out     out  valid/ready    key_out, red, green, blue
//  i_cfg_*   in   write enable   register index, 22-bit data
//
// load: written as the back end takes it; tick: rate, phase, sine, coef steps per oscillator
// render: 21 multiplies plus 3 scalings on the one shared multiplier
// a two-entry queue lets the front end keep taking items while the back end works
// the result register holds a finished item; a render stalls only at its final write
// synchronous reset restores sharpness and speed and clears oscillators and color stores
`default_nettype none
module plasma_led_color_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plce_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [plce_pkg::CFG_DW-1:0]   i_cfg_data,
    plce_in_if.sink                       i_in,
    plce_out_if.source                    o_out
);
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    plce_pkg::t_op q_in;
    plce_pkg::t_op q_out;

    plce_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_item (q_in)
    );

    plce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    plce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (q_empty),
        .i_item     (q_out),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

// ----- hw/rtl/plce_front.sv -----
// front end: accepts input items, drops the ones that do nothing, classifies the rest
`default_nettype none
module plce_front (
    plce_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output plce_pkg::t_op    o_item
);
    logic keep;

    always_comb begin
        keep        = 1'b0;
        o_item.kind = plce_pkg::K_TICK;
        unique case (i_in.mode)
            plce_pkg::MODE_TICK: begin
                keep = 1'b1;
            end
            plce_pkg::MODE_RENDER: begin
                keep        = (32'(i_in.key_index) < plce_pkg::KEY_COUNT);
                o_item.kind = plce_pkg::K_RENDER;
            end
            plce_pkg::MODE_LOAD: begin
                keep        = (32'(i_in.osc_index) < plce_pkg::OSCILLATORS);
                o_item.kind = plce_pkg::K_LOAD;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_item.key   = i_in.key_index;
        o_item.pos_x = i_in.pos_x;
        o_item.pos_y = i_in.pos_y;
        o_item.osc   = i_in.osc_index;
        o_item.phase = i_in.osc_phase;
        o_item.rate  = i_in.osc_rate;
    end

    // dropped items are still taken off the channel
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && keep;

endmodule
`default_nettype wire

// ----- hw/rtl/plce_queue.sv -----
// short queue between front end and back end
`default_nettype none
module plce_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  plce_pkg::t_op    i_item,
    input  logic             i_pop,
    output plce_pkg::t_op    o_item,
    output logic             o_full,
    output logic             o_empty
);
    plce_pkg::t_op            r_mem [plce_pkg::QUEUE_DEPTH];
    logic [plce_pkg::QAW-1:0] r_wp;
    logic [plce_pkg::QAW-1:0] r_rp;
    logic [plce_pkg::QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (plce_pkg::QAW + 1)'(plce_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == plce_pkg::QAW'(plce_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == plce_pkg::QAW'(plce_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/plce_back.sv -----
// back end: oscillator bank, shared multiplier, color store and result register
`default_nettype none
module plce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plce_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [plce_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          i_empty,
    input  plce_pkg::t_op                 i_item,
    output logic                          o_pop,
    plce_out_if.source                    o_out
);
    localparam int OSC = plce_pkg::OSCILLATORS;

    plce_pkg::t_bstate r_state;
    plce_pkg::t_bstate n_state;

    logic [plce_pkg::CFG_DW-1:0] r_sharp;
    logic [plce_pkg::CFG_DW-1:0] r_speed;
    logic [15:0]                 r_phase [OSC];
    logic [15:0]                 r_rate  [OSC];
    logic signed [31:0]          r_coef  [OSC];
    logic [plce_pkg::OSC_AW-1:0] r_osc;
    logic [1:0]                  r_quad;
    logic [plce_pkg::SINE_AW-1:0] r_sidx;
    logic signed [65:0]          r_prod;

    logic [7:0]         r_key;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_xx;
    logic signed [31:0] r_yy;
    logic signed [31:0] r_xy;
    logic signed [31:0] r_old [3];
    logic signed [31:0] r_new [3];
    logic signed [34:0] r_acc;
    logic [1:0]         r_grp;
    logic [2:0]         r_pos;
    logic [14:0]        r_md;

    logic [95:0] r_mem [plce_pkg::KEY_COUNT];
    logic        r_vld [plce_pkg::KEY_COUNT];
    logic [95:0] r_rd;
    logic        r_rd_vld;

    logic       r_out_vld;
    logic [7:0] r_out_key;
    logic [7:0] r_out_r;
    logic [7:0] r_out_g;
    logic [7:0] r_out_b;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mem_we;
    logic [37:0]        tk_rnd;
    logic [15:0]        tk_p;
    logic [14:0]        tk_q;
    logic [27:0]        tk_qm;
    logic [13:0]        tk_idx;
    logic [39:0]        cf_rnd;
    logic signed [31:0] cf_mag;
    logic signed [31:0] prod_q;
    logic [4:0]         cidx;
    logic signed [31:0] opnd;
    logic [30:0]        md_full;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round half away from zero by 2^16, then saturate
    function automatic logic signed [31:0] rq(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] r;
        mag = v[65] ? 66'(-v) : 66'(v);
        r   = (mag + 66'd32768) >> 16;
        if (v[65]) begin
            if (r > 66'h80000000) begin
                return 32'sh80000000;
            end
            return 32'(-r);
        end
        if (r > 66'h7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end
        return 32'(r);
    endfunction

    function automatic logic signed [31:0] slew(input logic signed [31:0] t,
                                                input logic signed [31:0] old,
                                                input logic [14:0] md);
        logic signed [35:0] d;
        logic signed [35:0] res;
        d   = 36'(t) - 36'(old);
        res = 36'(t);
        if (d > $signed({21'b0, md})) begin
            res = 36'(old) + $signed({21'b0, md});
        end
        if (d < -$signed({21'b0, md})) begin
            res = 36'(old) - $signed({21'b0, md});
        end
        return sat32(res);
    endfunction

    function automatic logic [7:0] to_byte(input logic signed [31:0] c);
        logic [32:0] m;
        logic [24:0] t;
        m = c[31] ? 33'(-36'(c)) : 33'(c);
        if (m > 33'd65536) begin
            m = 33'd65536;
        end
        t = 25'(m[16:0]) * 25'd255;
        return t[23:16];
    endfunction

    function automatic logic [plce_pkg::KEY_AW-1:0] KEY_AW_CAST(input logic [7:0] k);
        return plce_pkg::KEY_AW'(k);
    endfunction

    // phase, sine index, coef, term index, slew limit
    always_comb begin
        tk_rnd = r_prod[37:0] + 38'd32768;
        tk_p   = r_phase[r_osc] + tk_rnd[31:16] + 16'd1;
        tk_q   = tk_p[14] ? 15'd16384 - {1'b0, tk_p[13:0]} : {1'b0, tk_p[13:0]};
        tk_qm  = 28'(tk_q) * 28'(plce_pkg::SINE_TABLE_DEPTH);
        tk_idx = tk_qm[27:14];
        if (32'(tk_idx) > plce_pkg::SINE_TABLE_DEPTH) begin
            tk_idx = 14'(plce_pkg::SINE_TABLE_DEPTH);
        end
        cf_rnd = r_prod[39:0] + 40'd32768;
        cf_mag = $signed({8'b0, cf_rnd[39:16]});
        prod_q = rq(r_prod);
        cidx   = 5'(r_grp) * 5'd6 + 5'(r_pos);
        md_full = 31'(r_speed) * 31'(plce_pkg::SLEW_Q16) + 31'd32768;
    end

    // second factor of each term, by color group and position
    always_comb begin
        case (r_pos)
            3'd0:    opnd = r_x;
            3'd1:    opnd = r_y;
            3'd2: begin
                case (r_grp)
                    2'd0:    opnd = sat32(36'(r_xx) + 36'(plce_pkg::ONE_Q16));
                    2'd1:    opnd = r_xx;
                    default: opnd = sat32(36'(plce_pkg::ONE_Q16) - 36'(r_xy));
                endcase
            end
            3'd3: begin
                case (r_grp)
                    2'd0:    opnd = r_xy;
                    2'd1:    opnd = sat32(36'(r_yy) - 36'(plce_pkg::ONE_Q16));
                    default: opnd = r_yy;
                endcase
            end
            3'd4:    opnd = (r_grp == 2'd0) ? r_old[1] : r_old[0];
            default: opnd = (r_grp == 2'd2) ? r_old[1] : r_old[2];
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        mem_we  = 1'b0;
        unique case (r_state)
            plce_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_item.kind)
                        plce_pkg::K_TICK:   n_state = plce_pkg::B_TK_RATE;
                        plce_pkg::K_RENDER: n_state = plce_pkg::B_SQ_XX;
                        default:            n_state = plce_pkg::B_IDLE;
                    endcase
                end
            end
            plce_pkg::B_TK_RATE: begin
                mul_a   = $signed({17'b0, r_rate[r_osc]});
                mul_b   = $signed({11'b0, r_speed});
                n_state = plce_pkg::B_TK_PHASE;
            end
            plce_pkg::B_TK_PHASE: n_state = plce_pkg::B_TK_SINE;
            plce_pkg::B_TK_SINE: begin
                mul_a   = $signed({16'b0, plce_pkg::SINE_TAB[r_sidx]});
                mul_b   = $signed({11'b0, r_sharp});
                n_state = plce_pkg::B_TK_COEF;
            end
            plce_pkg::B_TK_COEF: begin
                n_state = (r_osc == plce_pkg::OSC_AW'(OSC - 1)) ? plce_pkg::B_IDLE
                                                                : plce_pkg::B_TK_RATE;
            end
            plce_pkg::B_SQ_XX: begin
                mul_a   = 33'(r_x);
                mul_b   = 33'(r_x);
                n_state = plce_pkg::B_SQ_YY;
            end
            plce_pkg::B_SQ_YY: begin
                mul_a   = 33'(r_y);
                mul_b   = 33'(r_y);
                n_state = plce_pkg::B_SQ_XY;
            end
            plce_pkg::B_SQ_XY: begin
                mul_a   = 33'(r_x);
                mul_b   = 33'(r_y);
                n_state = plce_pkg::B_SQ_DONE;
            end
            plce_pkg::B_SQ_DONE: n_state = plce_pkg::B_TM_MUL;
            plce_pkg::B_TM_MUL: begin
                mul_a   = 33'(r_coef[cidx]);
                mul_b   = 33'(opnd);
                n_state = plce_pkg::B_TM_ACC;
            end
            plce_pkg::B_TM_ACC: begin
                n_state = (r_pos == 3'd5) ? plce_pkg::B_SC_MUL : plce_pkg::B_TM_MUL;
            end
            plce_pkg::B_SC_MUL: begin
                mul_a   = 33'(sat32(36'(r_acc)));
                mul_b   = 33'(plce_pkg::SEVEN_TENTHS_Q16);
                n_state = plce_pkg::B_SC_ACC;
            end
            plce_pkg::B_SC_ACC: begin
                n_state = (r_grp == 2'd2) ? plce_pkg::B_WRITE : plce_pkg::B_TM_MUL;
            end
            plce_pkg::B_WRITE: begin
                if (!r_out_vld || o_out.ready) begin
                    mem_we  = 1'b1;
                    n_state = plce_pkg::B_IDLE;
                end
            end
            default: n_state = plce_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plce_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sharp   <= plce_pkg::SHARPNESS_RESET;
            r_speed   <= plce_pkg::SPEED_RESET;
            r_out_vld <= 1'b0;
            for (int i = 0; i < OSC; i++) begin
                r_phase[i] <= '0;
                r_rate[i]  <= '0;
                r_coef[i]  <= '0;
            end
            for (int k = 0; k < plce_pkg::KEY_COUNT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    plce_pkg::CFG_SHARPNESS: r_sharp <= i_cfg_data;
                    plce_pkg::CFG_SPEED:     r_speed <= i_cfg_data;
                    default:                 r_sharp <= r_sharp;
                endcase
            end
            if (o_pop && i_item.kind == plce_pkg::K_LOAD) begin
                r_phase[i_item.osc] <= i_item.phase;
                r_rate[i_item.osc]  <= i_item.rate;
            end
            if (r_state == plce_pkg::B_TK_PHASE) begin
                r_phase[r_osc] <= tk_p;
            end
            if (r_state == plce_pkg::B_TK_COEF) begin
                r_coef[r_osc] <= r_quad[1] ? -cf_mag : cf_mag;
            end
            if (mem_we) begin
                r_vld[KEY_AW_CAST(r_key)] <= 1'b1;
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_rd     <= r_mem[KEY_AW_CAST(r_key)];
        r_rd_vld <= r_vld[KEY_AW_CAST(r_key)];
        if (o_pop) begin
            r_osc <= '0;
            r_key <= i_item.key;
            r_x   <= i_item.pos_x;
            r_y   <= i_item.pos_y;
            r_md  <= md_full[30:16];
        end
        unique case (r_state)
            plce_pkg::B_TK_PHASE: begin
                r_quad <= tk_p[15:14];
                r_sidx <= plce_pkg::SINE_AW'(tk_idx);
            end
            plce_pkg::B_TK_COEF: r_osc <= r_osc + 1'b1;
            plce_pkg::B_SQ_YY: begin
                r_xx     <= prod_q;
                // a row never written reads as zero
                r_old[0] <= r_rd_vld ? r_rd[31:0]  : '0;
                r_old[1] <= r_rd_vld ? r_rd[63:32] : '0;
                r_old[2] <= r_rd_vld ? r_rd[95:64] : '0;
            end
            plce_pkg::B_SQ_XY: r_yy <= prod_q;
            plce_pkg::B_SQ_DONE: begin
                r_xy  <= prod_q;
                r_acc <= '0;
                r_grp <= '0;
                r_pos <= '0;
            end
            plce_pkg::B_TM_ACC: begin
                r_acc <= r_acc + 35'(prod_q);
                if (r_pos != 3'd5) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            plce_pkg::B_SC_ACC: begin
                r_new[r_grp] <= slew(prod_q, r_old[r_grp], r_md);
                r_acc        <= '0;
                r_pos        <= '0;
                r_grp        <= r_grp + 1'b1;
            end
            default: begin
            end
        endcase
        if (mem_we) begin
            r_mem[KEY_AW_CAST(r_key)] <= {r_new[2], r_new[1], r_new[0]};
            r_out_key <= r_key;
            r_out_r   <= to_byte(r_new[0]);
            r_out_g   <= to_byte(r_new[1]);
            r_out_b   <= to_byte(r_new[2]);
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.key_out = r_out_key;
    assign o_out.red     = r_out_r;
    assign o_out.green   = r_out_g;
    assign o_out.blue    = r_out_b;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the plasma led color engine: scoreboard class, drivers and checks
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int OSC_TOTAL = plce_pkg::OSCILLATORS;
    localparam int KEYS = plce_pkg::KEY_COUNT;
    localparam int TABLE_N = plce_pkg::SINE_TABLE_DEPTH;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  key;
        logic [31:0] px;
        logic [31:0] py;
        logic [4:0]  osc;
        logic [15:0] ph;
        logic [15:0] rt;
    } plasma_item_t;

    typedef struct {
        logic [7:0] key;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } led_color_t;

    class color_scoreboard;
        bit [21:0]   sharp;
        bit [21:0]   spd;
        bit [15:0]   phase_q[OSC_TOTAL];
        bit [15:0]   rate_q[OSC_TOTAL];
        int          coef[OSC_TOTAL];
        int          red_mem[KEYS];
        int          grn_mem[KEYS];
        int          blu_mem[KEYS];
        bit [16:0]   sine_lut[TABLE_N + 1];
        led_color_t  pending_colors[$];
        int          renders;
        int          ticks;
        int          loads;

        function new();
            bit [63:0] x, term, pos, neg, s;
            sharp = 22'd65536;
            spd = 22'd655360;
            foreach (phase_q[i]) begin
                phase_q[i] = '0; rate_q[i] = '0; coef[i] = 0;
            end
            foreach (red_mem[i]) begin
                red_mem[i] = 0; grn_mem[i] = 0; blu_mem[i] = 0;
            end
            // quarter-wave sine by a seven-term series in q30
            for (int i = 0; i <= TABLE_N; i++) begin
                x = (64'(i) * 64'd1686629713) / TABLE_N;
                term = x; pos = x; neg = '0;
                for (int k = 1; k <= 6; k++) begin
                    term = (((term * x) >> 30) * x) >> 30;
                    term = term / 64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) neg += term; else pos += term;
                end
                s = (pos > neg) ? pos - neg : 64'd0;
                s = (s + 64'd8192) >> 14;
                sine_lut[i] = (s > 64'd65536) ? 17'd65536 : 17'(s);
            end
            renders = 0; ticks = 0; loads = 0;
        endfunction

        function longint rnd_shift(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fmul(longint a, longint b);
            return clip32(rnd_shift(a * b, 16));
        endfunction

        function int limit_step(longint target, longint old, longint maxd);
            longint d;
            d = target - old;
            if (d > maxd) target = old + maxd;
            if (d < -maxd) target = old - maxd;
            return int'(clip32(target));
        endfunction

        function logic [7:0] intensity(int c);
            longint m;
            m = (c < 0) ? -longint'(c) : longint'(c);
            if (m > 65536) m = 65536;
            return 8'((m * 255) >>> 16);
        endfunction

        function void advance_oscillators();
            longint inc;
            bit [15:0] p;
            bit [1:0]  quad;
            int q, idx;
            longint mag;
            for (int i = 0; i < OSC_TOTAL; i++) begin
                inc = ((longint'(rate_q[i]) * longint'(spd) + 32768) >>> 16) + 1;
                p = 16'(longint'(phase_q[i]) + inc);
                quad = p[15:14];
                q = int'(p[13:0]);
                if (quad[0]) q = 16384 - q;
                idx = (q * TABLE_N) >> 14;
                if (idx > TABLE_N) idx = TABLE_N;
                mag = (longint'(sine_lut[idx]) * longint'(sharp) + 32768) >>> 16;
                phase_q[i] = p;
                coef[i] = (quad >= 2) ? -int'(mag) : int'(mag);
            end
        endfunction

        function void note_item(plasma_item_t it);
            longint x, y, xx, yy, xy, r, g, b, sr, sg, sb, maxd;
            led_color_t e;
            case (it.mode)
                plce_pkg::MODE_TICK: begin
                    advance_oscillators();
                    ticks++;
                end
                plce_pkg::MODE_LOAD: begin
                    if (it.osc < OSC_TOTAL) begin
                        phase_q[it.osc] = it.ph;
                        rate_q[it.osc] = it.rt;
                        loads++;
                    end
                end
                plce_pkg::MODE_RENDER: begin
                    x = longint'(signed'(it.px));
                    y = longint'(signed'(it.py));
                    xx = fmul(x, x); yy = fmul(y, y); xy = fmul(x, y);
                    r = red_mem[it.key]; g = grn_mem[it.key]; b = blu_mem[it.key];
                    sr = fmul(coef[0], x) + fmul(coef[1], y) + fmul(coef[2], clip32(xx + 65536))
                       + fmul(coef[3], xy) + fmul(coef[4], g) + fmul(coef[5], b);
                    sg = fmul(coef[6], x) + fmul(coef[7], y) + fmul(coef[8], xx)
                       + fmul(coef[9], clip32(yy - 65536)) + fmul(coef[10], r)
                       + fmul(coef[11], b);
                    sb = fmul(coef[12], x) + fmul(coef[13], y)
                       + fmul(coef[14], clip32(65536 - xy)) + fmul(coef[15], yy)
                       + fmul(coef[16], r) + fmul(coef[17], g);
                    sr = rnd_shift(clip32(sr) * 45875, 16);
                    sg = rnd_shift(clip32(sg) * 45875, 16);
                    sb = rnd_shift(clip32(sb) * 45875, 16);
                    maxd = (longint'(spd) * 262 + 32768) >>> 16;
                    red_mem[it.key] = limit_step(sr, r, maxd);
                    grn_mem[it.key] = limit_step(sg, g, maxd);
                    blu_mem[it.key] = limit_step(sb, b, maxd);
                    e.key = it.key;
                    e.r = intensity(red_mem[it.key]);
                    e.g = intensity(grn_mem[it.key]);
                    e.b = intensity(blu_mem[it.key]);
                    pending_colors.push_back(e);
                    renders++;
                end
                default: ;
            endcase
        endfunction

        // empty string when the color matches the oldest expected one
        function string check_color(led_color_t got);
            led_color_t e;
            string msg;
            if (pending_colors.size() == 0)
                return $sformatf("unexpected color for key %0d", got.key);
            e = pending_colors.pop_front();
            msg = "";
            if (got.key != e.key) msg = {msg, $sformatf(" key %0d/%0d", got.key, e.key)};
            if (got.r != e.r) msg = {msg, $sformatf(" red %0d/%0d", got.r, e.r)};
            if (got.g != e.g) msg = {msg, $sformatf(" green %0d/%0d", got.g, e.g)};
            if (got.b != e.b) msg = {msg, $sformatf(" blue %0d/%0d", got.b, e.b)};
            if (msg != "") msg = {"color mismatch (got/exp):", msg};
            return msg;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [plce_pkg::CFG_IW-1:0] i_cfg_idx;
    logic [plce_pkg::CFG_DW-1:0] i_cfg_data;

    plce_in_if  in_ch();
    plce_out_if out_ch();

    plasma_led_color_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    color_scoreboard sb;
    int errors = 0;
    int colors_seen = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_output = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic report(string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    task automatic send_item(plasma_item_t it);
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= it.mode;
        in_ch.key_index <= it.key;
        in_ch.pos_x     <= it.px;
        in_ch.pos_y     <= it.py;
        in_ch.osc_index <= it.osc;
        in_ch.osc_phase <= it.ph;
        in_ch.osc_rate  <= it.rt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(it);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [plce_pkg::CFG_IW-1:0] idx,
                             logic [plce_pkg::CFG_DW-1:0] val);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_colors.size() != 0) @(posedge i_clk);
        // a tick may still be running with nothing expected
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == plce_pkg::CFG_SHARPNESS) sb.sharp = val; else sb.spd = val;
    endtask

    function automatic plasma_item_t make_item(logic [1:0] m, logic [7:0] k, logic [31:0] x,
                                               logic [31:0] y, logic [4:0] o,
                                               logic [15:0] p, logic [15:0] r);
        plasma_item_t it;
        it.mode = m; it.key = k; it.px = x; it.py = y; it.osc = o; it.ph = p; it.rt = r;
        return it;
    endfunction

    function automatic plasma_item_t random_item();
        plasma_item_t it;
        int pick;
        it = make_item(2'($urandom), 8'($urandom), $urandom, $urandom, 5'($urandom),
                       16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.mode = plce_pkg::MODE_RENDER;
            if ($urandom_range(0, 3) != 0) begin
                // mostly small coordinates so the sums stay in range
                it.px = 32'($urandom_range(0, 524288)) - 32'd262144;
                it.py = 32'($urandom_range(0, 524288)) - 32'd262144;
            end
            if ($urandom_range(0, 1) == 0) it.key = 8'($urandom_range(0, 7));
        end else if (pick < 78) begin
            it.mode = plce_pkg::MODE_TICK;
        end else if (pick < 95) begin
            it.mode = plce_pkg::MODE_LOAD;
            it.osc = 5'($urandom_range(0, OSC_TOTAL - 1));
        end else if (pick < 98) begin
            it.mode = plce_pkg::MODE_LOAD;
        end else begin
            it.mode = MODE_NONE;
        end
        return it;
    endfunction

    // result side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_output = 0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        led_color_t got;
        string msg;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.key = out_ch.key_out;
                got.r = out_ch.red;
                got.g = out_ch.green;
                got.b = out_ch.blue;
                colors_seen++;
                msg = sb.check_color(got);
                if (msg != "") report(msg);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        logic [plce_pkg::CFG_DW-1:0] sharp_set [6];
        logic [plce_pkg::CFG_DW-1:0] speed_set [6];
        sb = new();
        sharp_set = '{22'd32768, 22'd3276800, 22'd65536, 22'h3FFFFF, 22'd500000, 22'd131072};
        speed_set = '{22'd6554, 22'd3276800, 22'd655360, 22'd100000, 22'h3FFFFF, 22'd0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = plce_pkg::MODE_TICK;
        in_ch.key_index = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.osc_index = '0;
        in_ch.osc_phase = '0;
        in_ch.osc_rate = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero coefficients, extreme loads, ignored items, extreme positions
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd0, 32'h7FFFFFFF, 32'h80000000,
                            '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_TICK, '0, '0, '0, '0, '0, '0));
        for (int i = 0; i < OSC_TOTAL; i += 2)
            send_item(make_item(plce_pkg::MODE_LOAD, '0, '0, '0, 5'(i), 16'hFFFF, 16'hFFFF));
        send_item(make_item(plce_pkg::MODE_LOAD, '0, '0, '0, 5'd1, 16'h4000, 16'd0));
        send_item(make_item(plce_pkg::MODE_LOAD, '0, '0, '0, 5'd31, 16'h1234, 16'h5678));
        send_item(make_item(MODE_NONE, 8'd255, 32'hFFFFFFFF, '0, '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_TICK, '0, '0, '0, '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd255, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd255, 32'h80000000, 32'h80000000,
                            '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd1, 32'd0, 32'd0, '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd1, 32'h00010000, 32'hFFFF0000,
                            '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_TICK, '0, '0, '0, '0, '0, '0));
        send_item(make_item(plce_pkg::MODE_RENDER, 8'd1, 32'h00010000, 32'hFFFF0000,
                            '0, '0, '0));

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(plce_pkg::CFG_SHARPNESS, sharp_set[ph]);
            write_reg(plce_pkg::CFG_SPEED, speed_set[ph]);
            case (ph / 2)
                0: begin tx_idle_pct = 10; rx_idle_pct = 48; end
                1: begin tx_idle_pct = 48; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (ph == 4) hold_output = 1;
            for (int n = 0; n < 322; n++) send_item(random_item());
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending_colors.size() != 0) report("expected colors never arrived");
        $display("tb: %0d renders checked, %0d ticks, %0d loads", sb.renders, sb.ticks,
                 sb.loads);
        $display("tb: six register settings, sender and receiver stalls, one long hold-off");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
